[sv/rws_pkg.sv]
// Shared constants, types and control structs for the running statistics block.
`timescale 1ns / 1ps
`default_nettype none

package rws_pkg;

  localparam int WINDOW = 8;

  localparam int SCORE_W = 15;
  localparam int DUR_W   = 16;
  localparam int RANGE_W = 16;
  localparam int COUNT_W = 16;

  localparam int SSUM_W = 31;
  localparam int DSUM_W = 32;
  localparam int RSUM_W = 32;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int WSS_W  = SCORE_W + $clog2(WINDOW);
  localparam int WRS_W  = RANGE_W + $clog2(WINDOW);

  localparam int NUM_W         = 32;
  localparam int DEN_W         = 16;
  localparam int QUO_W         = 16;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS     = QUO_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(25600);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(WINDOW);
  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(WINDOW - 1);

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [DUR_W-1:0]   dur_t;
  typedef logic [RANGE_W-1:0] range_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    SEL_SCORE  = 3'd0,
    SEL_DUR    = 3'd1,
    SEL_RANGE  = 3'd2,
    SEL_WSCORE = 3'd3,
    SEL_WRANGE = 3'd4
  } div_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     div_start;
    logic     div_step;
    logic     div_store;
    logic     emit;
    div_sel_t sel;
  } rws_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } rws_status_t;

endpackage

`default_nettype wire

[sv/rws_if.sv]
// Valid/ready channel interfaces for rep beats and statistics beats.
`timescale 1ns / 1ps
`default_nettype none

interface rws_in_if;
  logic            valid;
  logic            ready;
  logic            mode;
  rws_pkg::score_t rep_score;
  rws_pkg::dur_t   rep_duration_ms;
  rws_pkg::range_t rep_range;

  modport source (output valid, mode, rep_score, rep_duration_ms, rep_range, input ready);
  modport sink   (input valid, mode, rep_score, rep_duration_ms, rep_range, output ready);
endinterface

interface rws_out_if;
  logic            valid;
  logic            ready;
  rws_pkg::count_t rep_count;
  rws_pkg::score_t mean_score;
  rws_pkg::score_t best_score;
  rws_pkg::score_t worst_score;
  rws_pkg::dur_t   mean_duration;
  rws_pkg::range_t mean_range;
  rws_pkg::score_t window_mean_score;
  rws_pkg::range_t window_mean_range;
  logic            count_full;

  modport source (output valid, rep_count, mean_score, best_score, worst_score,
                  mean_duration, mean_range, window_mean_score, window_mean_range,
                  count_full, input ready);
  modport sink   (input valid, rep_count, mean_score, best_score, worst_score,
                  mean_duration, mean_range, window_mean_score, window_mean_range,
                  count_full, output ready);
endinterface

`default_nettype wire

[sv/rws_ctrl.sv]
// Controller: sequences the update, five serial divisions and the result beat.
`timescale 1ns / 1ps
`default_nettype none

module rws_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rws_pkg::rws_status_t status,
  output rws_pkg::rws_cmd_t    cmd
);
  import rws_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_ITER  = 5'b00100,
    ST_STORE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  div_sel_t              sel_r, sel_nxt;
  logic [STEP_CNT_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    step_nxt      = step_r;
    cmd           = '0;
    cmd.sel       = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          sel_nxt   = SEL_SCORE;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        step_nxt      = '0;
        state_nxt     = ST_ITER;
      end
      ST_ITER: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.div_store = 1'b1;
        if (sel_r == SEL_WRANGE) begin
          state_nxt = ST_EMIT;
        end else begin
          sel_nxt   = div_sel_t'(sel_r + 3'd1);
          state_nxt = ST_START;
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= SEL_SCORE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      step_r  <= step_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER && step_r == STEP_CNT_W'(DIV_STEPS - 1)) |=> state_r == ST_STORE)
    else $error("division did not end after its step count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STORE && sel_r == SEL_WRANGE) |=> state_r == ST_EMIT)
    else $error("last division did not lead to emit");

endmodule

`default_nettype wire

[sv/rws_dp.sv]
// Datapath: running sums, best/worst, window ring, serial divider, result register.
`timescale 1ns / 1ps
`default_nettype none

module rws_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rws_pkg::rws_cmd_t    cmd,
  output rws_pkg::rws_status_t status,
  rws_in_if.sink               in_bus,
  rws_out_if.source            out_bus
);
  import rws_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SSUM_W-1:0]  ssum_r, ssum_nxt;
  logic [DSUM_W-1:0]  dsum_r, dsum_nxt;
  logic [RSUM_W-1:0]  rsum_r, rsum_nxt;
  score_t             best_r, best_nxt;
  score_t             worst_r, worst_nxt;
  logic [WSS_W-1:0]   wss_r, wss_nxt;
  logic [WRS_W-1:0]   wrs_r, wrs_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;

  score_t             win_score_r [WINDOW];
  range_t             win_range_r [WINDOW];

  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [DEN_W-1:0]   den_r;
  logic [NUM_W-1:0]   num_sel;
  logic [DEN_W-1:0]   den_sel;
  logic [QUO_W-1:0]   quo_val;

  score_t             q_score_r, q_wscore_r;
  dur_t               q_dur_r;
  range_t             q_range_r, q_wrange_r;

  logic               out_valid_r;
  count_t             out_count_r;
  score_t             out_mscore_r, out_best_r, out_worst_r, out_wscore_r;
  dur_t               out_mdur_r;
  range_t             out_mrange_r, out_wrange_r;
  logic               out_full_r;

  logic               accept;
  score_t             score_in;
  logic               win_full;
  score_t             old_score;
  range_t             old_range;

  assign accept    = in_bus.valid && cmd.in_ready;
  assign in_bus.ready = cmd.in_ready;
  assign status.in_valid = in_bus.valid;
  assign status.out_busy = out_valid_r && !out_bus.ready;

  assign score_in  = (in_bus.rep_score > SCORE_MAX) ? SCORE_MAX : in_bus.rep_score;
  assign win_full  = (fill_r == FILL_FULL);
  assign old_score = win_full ? win_score_r[slot_r] : '0;
  assign old_range = win_full ? win_range_r[slot_r] : '0;

  always_comb begin
    count_nxt = count_r;
    ssum_nxt  = ssum_r;
    dsum_nxt  = dsum_r;
    rsum_nxt  = rsum_r;
    best_nxt  = best_r;
    worst_nxt = worst_r;
    wss_nxt   = wss_r;
    wrs_nxt   = wrs_r;
    slot_nxt  = slot_r;
    fill_nxt  = fill_r;
    if (accept) begin
      if (in_bus.mode == MODE_CLEAR) begin
        count_nxt = '0;
        ssum_nxt  = '0;
        dsum_nxt  = '0;
        rsum_nxt  = '0;
        best_nxt  = '0;
        worst_nxt = '0;
        wss_nxt   = '0;
        wrs_nxt   = '0;
        slot_nxt  = '0;
        fill_nxt  = '0;
      end else begin
        if (count_r == '0) begin
          best_nxt  = score_in;
          worst_nxt = score_in;
        end else begin
          if (score_in > best_r)  best_nxt  = score_in;
          if (score_in < worst_r) worst_nxt = score_in;
        end
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
          ssum_nxt  = ssum_r + SSUM_W'(score_in);
          dsum_nxt  = dsum_r + DSUM_W'(in_bus.rep_duration_ms);
          rsum_nxt  = rsum_r + RSUM_W'(in_bus.rep_range);
        end
        wss_nxt  = wss_r - WSS_W'(old_score) + WSS_W'(score_in);
        wrs_nxt  = wrs_r - WRS_W'(old_range) + WRS_W'(in_bus.rep_range);
        if (!win_full) fill_nxt = fill_r + 1'b1;
        slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ssum_r  <= '0;
      dsum_r  <= '0;
      rsum_r  <= '0;
      best_r  <= '0;
      worst_r <= '0;
      wss_r   <= '0;
      wrs_r   <= '0;
      slot_r  <= '0;
      fill_r  <= '0;
    end else begin
      count_r <= count_nxt;
      ssum_r  <= ssum_nxt;
      dsum_r  <= dsum_nxt;
      rsum_r  <= rsum_nxt;
      best_r  <= best_nxt;
      worst_r <= worst_nxt;
      wss_r   <= wss_nxt;
      wrs_r   <= wrs_nxt;
      slot_r  <= slot_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_bus.mode == MODE_RECORD) begin
      win_score_r[slot_r] <= score_in;
      win_range_r[slot_r] <= in_bus.rep_range;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_SCORE: begin
        num_sel = NUM_W'(ssum_r);
        den_sel = DEN_W'(count_r);
      end
      SEL_DUR: begin
        num_sel = NUM_W'(dsum_r);
        den_sel = DEN_W'(count_r);
      end
      SEL_RANGE: begin
        num_sel = NUM_W'(rsum_r);
        den_sel = DEN_W'(count_r);
      end
      SEL_WSCORE: begin
        num_sel = NUM_W'(wss_r);
        den_sel = DEN_W'(fill_r);
      end
      SEL_WRANGE: begin
        num_sel = NUM_W'(wrs_r);
        den_sel = DEN_W'(fill_r);
      end
      default: begin
        num_sel = '0;
        den_sel = '0;
      end
    endcase
  end

  always_comb begin
    logic [DEN_W:0] rem_w;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      rem_w = {rem_nxt, quo_nxt[QUO_W-1]};
      if (rem_w >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(rem_w - {1'b0, den_r});
        quo_nxt = {quo_nxt[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_w[DEN_W-1:0];
        quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign quo_val = (den_r == '0) ? '0 : quo_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= num_sel[NUM_W-1:QUO_W];
      quo_r <= num_sel[QUO_W-1:0];
      den_r <= den_sel;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.sel)
        SEL_SCORE:  q_score_r  <= quo_val[SCORE_W-1:0];
        SEL_DUR:    q_dur_r    <= quo_val[DUR_W-1:0];
        SEL_RANGE:  q_range_r  <= quo_val[RANGE_W-1:0];
        SEL_WSCORE: q_wscore_r <= quo_val[SCORE_W-1:0];
        SEL_WRANGE: q_wrange_r <= quo_val[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count_r  <= count_r;
      out_mscore_r <= q_score_r;
      out_best_r   <= best_r;
      out_worst_r  <= worst_r;
      out_mdur_r   <= q_dur_r;
      out_mrange_r <= q_range_r;
      out_wscore_r <= q_wscore_r;
      out_wrange_r <= q_wrange_r;
      out_full_r   <= (count_r == COUNT_MAX);
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.rep_count         = out_count_r;
  assign out_bus.mean_score        = out_mscore_r;
  assign out_bus.best_score        = out_best_r;
  assign out_bus.worst_score       = out_worst_r;
  assign out_bus.mean_duration     = out_mdur_r;
  assign out_bus.mean_range        = out_mrange_r;
  assign out_bus.window_mean_score = out_wscore_r;
  assign out_bus.window_mean_range = out_wrange_r;
  assign out_bus.count_full        = out_full_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_bus.mode == MODE_CLEAR) |=> (count_r == '0 && fill_r == '0 && wss_r == '0))
    else $error("clear beat did not restore statistics");

  assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= FILL_FULL) && (slot_r <= SLOT_LAST))
    else $error("window fill or slot out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    best_r >= worst_r)
    else $error("best score below worst score");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_full_r == (out_count_r == COUNT_MAX)))
    else $error("count_full disagrees with rep count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (ssum_r == '0 && best_r == '0 && fill_r == '0))
    else $error("statistics present with zero rep count");

endmodule

`default_nettype wire

[sv/running_and_windowed_statistics_top.sv]
// Top level of the running and windowed rep statistics block.
//
//   channel  dir  handshake     beat contents
//   in_bus   in   valid/ready   mode, rep_score, rep_duration_ms, rep_range
//   out_bus  out  valid/ready   counts, cumulative and window means, best, worst, full flag
//
// Each accepted beat updates the statistics in its accept cycle, then runs five
// divisions on one shared radix-4 divider (each: load, 8 steps, store), then the
// result goes valid once the output register is free; the next beat is taken only
// after that, so the divisions and any output stall set the rate.
// The output register lets the next rep beat be taken while a result waits.
// Synchronous active-low reset clears all statistics and the result valid.
`timescale 1ns / 1ps
`default_nettype none

module running_and_windowed_statistics_top (
  input  wire       clk,
  input  wire       rst_n,
  rws_in_if.sink    in_bus,
  rws_out_if.source out_bus
);
  import rws_pkg::*;

  rws_cmd_t    cmd;
  rws_status_t status;

  rws_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  rws_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .status  (status),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

[verif/session_stats_checker.sv]
// Checker for the rep statistics block: predicts every statistics beat and compares it.
`timescale 1ns / 1ps

module session_stats_checker
  import rws_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rws_in_if    in_mon,
  rws_out_if   out_mon,
  output int   fail_count,
  output int   pending_results
);

  localparam int NUM_FIELDS  = 9;
  localparam int REPORT_MAX  = 10;

  typedef enum int {
    F_COUNT      = 0,
    F_MEAN_SCORE = 1,
    F_BEST       = 2,
    F_WORST      = 3,
    F_MEAN_DUR   = 4,
    F_MEAN_RANGE = 5,
    F_WIN_SCORE  = 6,
    F_WIN_RANGE  = 7,
    F_FULL       = 8
  } stat_field_e;

  typedef logic [NUM_FIELDS-1:0][15:0] stat_row_t;

  count_t            tally;
  logic [SSUM_W-1:0] score_total;
  logic [DSUM_W-1:0] dur_total;
  logic [RSUM_W-1:0] range_total;
  score_t            top_score;
  score_t            low_score;
  score_t            ring_score [WINDOW];
  range_t            ring_range [WINDOW];
  logic [WSS_W-1:0]  ring_score_total;
  logic [WRS_W-1:0]  ring_range_total;
  logic [SLOT_W-1:0] next_slot;
  logic [FILL_W-1:0] ring_fill;

  stat_row_t expected_stats [$];
  int        errors;
  int        beats_seen;

  function automatic logic [31:0] ratio(input logic [31:0] num, input logic [31:0] den);
    return (den == 0) ? 32'd0 : num / den;
  endfunction

  function automatic string field_label(input stat_field_e f);
    case (f)
      F_COUNT:      return "rep_count";
      F_MEAN_SCORE: return "mean_score";
      F_BEST:       return "best_score";
      F_WORST:      return "worst_score";
      F_MEAN_DUR:   return "mean_duration";
      F_MEAN_RANGE: return "mean_range";
      F_WIN_SCORE:  return "window_mean_score";
      F_WIN_RANGE:  return "window_mean_range";
      default:      return "count_full";
    endcase
  endfunction

  task automatic clear_session();
    tally            = '0;
    score_total      = '0;
    dur_total        = '0;
    range_total      = '0;
    top_score        = '0;
    low_score        = '0;
    ring_score_total = '0;
    ring_range_total = '0;
    next_slot        = '0;
    ring_fill        = '0;
    for (int i = 0; i < WINDOW; i++) begin
      ring_score[i] = '0;
      ring_range[i] = '0;
    end
  endtask

  task automatic fold_beat(input logic mode, input score_t raw_score, input dur_t dur,
                           input range_t rng, output stat_row_t row);
    score_t sc;
    sc = (raw_score > SCORE_MAX) ? SCORE_MAX : raw_score;
    if (mode == MODE_CLEAR) begin
      clear_session();
    end else begin
      if (tally == '0) begin
        top_score = sc;
        low_score = sc;
      end else begin
        if (sc > top_score) top_score = sc;
        if (sc < low_score) low_score = sc;
      end
      if (tally != COUNT_MAX) begin
        tally       = tally + 1'b1;
        score_total = score_total + sc;
        dur_total   = dur_total + dur;
        range_total = range_total + rng;
      end
      if (ring_fill == FILL_FULL) begin
        ring_score_total = ring_score_total - ring_score[next_slot];
        ring_range_total = ring_range_total - ring_range[next_slot];
      end else begin
        ring_fill = ring_fill + 1'b1;
      end
      ring_score[next_slot] = sc;
      ring_range[next_slot] = rng;
      ring_score_total      = ring_score_total + sc;
      ring_range_total      = ring_range_total + rng;
      next_slot             = (next_slot == SLOT_LAST) ? '0 : next_slot + 1'b1;
    end
    row               = '0;
    row[F_COUNT]      = 16'(tally);
    row[F_MEAN_SCORE] = 16'(SCORE_W'(ratio(32'(score_total), 32'(tally))));
    row[F_BEST]       = 16'(top_score);
    row[F_WORST]      = 16'(low_score);
    row[F_MEAN_DUR]   = 16'(ratio(32'(dur_total), 32'(tally)));
    row[F_MEAN_RANGE] = 16'(ratio(32'(range_total), 32'(tally)));
    row[F_WIN_SCORE]  = 16'(SCORE_W'(ratio(32'(ring_score_total), 32'(ring_fill))));
    row[F_WIN_RANGE]  = 16'(ratio(32'(ring_range_total), 32'(ring_fill)));
    row[F_FULL]       = 16'(tally == COUNT_MAX);
  endtask

  always @(posedge clk) begin
    stat_row_t seen;
    stat_row_t want;
    if (!rst_n) begin
      clear_session();
      expected_stats.delete();
      errors     = 0;
      beats_seen = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen               = '0;
        seen[F_COUNT]      = 16'(out_mon.rep_count);
        seen[F_MEAN_SCORE] = 16'(out_mon.mean_score);
        seen[F_BEST]       = 16'(out_mon.best_score);
        seen[F_WORST]      = 16'(out_mon.worst_score);
        seen[F_MEAN_DUR]   = 16'(out_mon.mean_duration);
        seen[F_MEAN_RANGE] = 16'(out_mon.mean_range);
        seen[F_WIN_SCORE]  = 16'(out_mon.window_mean_score);
        seen[F_WIN_RANGE]  = 16'(out_mon.window_mean_range);
        seen[F_FULL]       = 16'(out_mon.count_full);
        if (expected_stats.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("stats beat %0d arrived with nothing outstanding", beats_seen);
        end else begin
          want = expected_stats.pop_front();
          if (want !== seen) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("stats mismatch on beat %0d", beats_seen);
              for (int f = 0; f < NUM_FIELDS; f++)
                if (want[f] !== seen[f])
                  $display("  %s expected %0d actual %0d",
                           field_label(stat_field_e'(f)), want[f], seen[f]);
            end
          end
        end
        beats_seen++;
      end
      if (in_mon.valid && in_mon.ready) begin
        fold_beat(in_mon.mode, in_mon.rep_score, in_mon.rep_duration_ms, in_mon.rep_range,
                  want);
        expected_stats.push_back(want);
      end
    end
    fail_count      <= errors;
    pending_results <= expected_stats.size();
  end

endmodule

[verif/running_and_windowed_statistics_top_tb.sv]
// Testbench top: drives rep beats, stalls the result side and reports the verdict.
`timescale 1ns / 1ps

module running_and_windowed_statistics_top_tb;
  import rws_pkg::*;

  localparam int CYCLE_LIMIT  = 300_000;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 150;

  logic clk = 1'b0;
  logic rst_n;
  int   fails;
  int   pending;
  int   cycle_count = 0;
  int   hold_req = 0;
  int   hold_served = 0;
  logic rx_fast = 1'b0;

  rws_in_if  in_bus ();
  rws_out_if out_bus ();

  always #2 clk = ~clk;

  running_and_windowed_statistics_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  session_stats_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .fail_count      (fails),
    .pending_results (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("running_and_windowed_statistics_top_tb: errors");
      $finish;
    end
  end

  function automatic score_t any_score();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SCORE_MAX;
      2:       return score_t'($urandom_range(25601, 32767));
      3:       return score_t'($urandom_range(0, 255));
      default: return score_t'($urandom_range(0, 25600));
    endcase
  endfunction

  function automatic logic [15:0] any_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      3:       return 16'($urandom_range(65280, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // Hold the beat until the block takes it.
  task automatic offer(input logic mode, input score_t sc, input dur_t dur, input range_t rng);
    in_bus.valid           <= 1'b1;
    in_bus.mode            <= mode;
    in_bus.rep_score       <= sc;
    in_bus.rep_duration_ms <= dur;
    in_bus.rep_range       <= rng;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      in_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic run_random(input int count);
    int burst;
    burst = $urandom_range(1, 16);
    for (int n = 0; n < count; n++) begin
      offer(($urandom_range(0, 29) == 0) ? MODE_CLEAR : MODE_RECORD,
            any_score(), any_word(), any_word());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
      end
    end
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int style;
    int seg_len;
    int period;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_served != hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_served++;
      end else if (rx_fast) begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end else begin
        style   = $urandom_range(0, 3);
        seg_len = $urandom_range(4, 48);
        period  = $urandom_range(2, 6);
        for (int c = 0; c < seg_len; c++) begin
          case (style)
            0:       out_bus.ready <= 1'b1;
            1:       out_bus.ready <= 1'($urandom_range(0, 1));
            2:       out_bus.ready <= ($urandom_range(0, 3) != 0);
            default: out_bus.ready <= ((c % period) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    rst_n                  <= 1'b0;
    in_bus.valid           <= 1'b0;
    in_bus.mode            <= MODE_RECORD;
    in_bus.rep_score       <= '0;
    in_bus.rep_duration_ms <= '0;
    in_bus.rep_range       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(MODE_CLEAR, score_t'(32767), 16'hFFFF, 16'hFFFF);
    offer(MODE_RECORD, '0, 16'h0000, 16'h0000);
    offer(MODE_RECORD, SCORE_MAX, 16'hFFFF, 16'hFFFF);
    offer(MODE_RECORD, score_t'(32767), 16'h0001, 16'h0001);
    idle_for(3);
    offer(MODE_RECORD, score_t'(25601), 16'h0000, 16'hFFFF);
    offer(MODE_RECORD, score_t'(1), 16'hFFFF, 16'h0000);
    for (int n = 0; n < 8; n++)
      offer(MODE_RECORD, n[0] ? '0 : SCORE_MAX, n[0] ? 16'h0000 : 16'hFFFF,
            n[0] ? 16'hFFFF : 16'h0000);
    offer(MODE_CLEAR, score_t'(12345), 16'h0002, 16'h0003);
    idle_for(5);
    offer(MODE_RECORD, score_t'(12800), 16'd500, 16'd700);
    offer(MODE_RECORD, score_t'(100), 16'd40000, 16'd3);
    offer(MODE_CLEAR, '0, 16'h0000, 16'h0000);

    run_random(150);

    // Stall the result side while beats keep coming.
    hold_req <= hold_req + 1;
    for (int n = 0; n < 10; n++)
      offer(MODE_RECORD, any_score(), any_word(), any_word());

    run_random(150);
    wait_drained();
    run_random(150);

    offer(MODE_CLEAR, '0, 16'h0000, 16'h0000);
    rx_fast <= 1'b1;
    offer(MODE_RECORD, SCORE_MAX, 16'hFFFF, 16'hFFFF);
    offer(MODE_RECORD, '0, 16'h0000, 16'h0000);
    offer(MODE_RECORD, score_t'(32767), 16'h1234, 16'hFFFF);
    for (int n = 0; n < 8; n++)
      offer(MODE_RECORD, any_score(), any_word(), any_word());
    rx_fast <= 1'b0;
    offer(MODE_CLEAR, any_score(), any_word(), any_word());
    offer(MODE_RECORD, any_score(), any_word(), any_word());

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("running_and_windowed_statistics_top_tb: clean");
    else
      $display("running_and_windowed_statistics_top_tb: errors");
    $finish;
  end

endmodule
